[rtl/core/vm_scalar_builtin_alu_top_assert.svh]
// Assertion macros for the scalar builtin ALU.
`ifndef VM_SCALAR_BUILTIN_ALU_TOP_ASSERT_SVH
`define VM_SCALAR_BUILTIN_ALU_TOP_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define VSBA_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define VSBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/vsba_pkg.sv]
// Shared types and constants of the scalar builtin ALU.
package vsba_pkg;

  localparam int unsigned VW = 64;
  localparam int unsigned DW = 64;

  typedef enum logic [3:0] {
    K_ABS    = 4'd0,
    K_MIN    = 4'd1,
    K_MAX    = 4'd2,
    K_CLIP   = 4'd3,
    K_IDIV   = 4'd4,
    K_IMOD   = 4'd5,
    K_ISINT  = 4'd6,
    K_ORD    = 4'd7,
    K_CHR    = 4'd8,
    K_LETTER = 4'd9,
    K_DIGIT  = 4'd10,
    K_SPACE  = 4'd11,
    K_VOWEL  = 4'd12,
    K_LOWER  = 4'd13,
    K_UPPER  = 4'd14
  } kind_e;

  localparam logic [1:0] TAG_INT   = 2'd0;
  localparam logic [1:0] TAG_CHAR  = 2'd1;
  localparam logic [1:0] TAG_FLOAT = 2'd2;

  localparam logic [1:0] RES_INT  = 2'd0;
  localparam logic [1:0] RES_CHAR = 2'd1;
  localparam logic [1:0] RES_BOOL = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TYPE  = 2'd1;
  localparam logic [1:0] ST_VALUE = 2'd2;
  localparam logic [1:0] ST_FLOAT = 2'd3;

  localparam logic [7:0] CHAR_MAX_CODE = 8'd255;
  localparam logic [7:0] CASE_DIST     = 8'h20;

  // Payload carried down the pipeline; rem and quo form the divider's shift pair.
  typedef struct packed {
    logic [VW-1:0] rem;
    logic [VW-1:0] quo;
    logic [VW-1:0] ub;
    logic [VW-1:0] bval;
    logic          neg_a;
    logic          neg_b;
    logic          is_div;
    logic          is_mod;
    logic [VW-1:0] res_value;
    logic [1:0]    res_tag;
    logic [1:0]    status;
  } pipe_t;

  typedef struct packed {
    logic [DW-1:0] value;
    logic [1:0]    tag;
    logic [1:0]    status;
  } out_item_t;

endpackage

[rtl/core/vsba_decode.sv]
// First stage: arity and tag checks, the non-division results and divider setup.
module vsba_decode (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [3:0]              kind_i,
  input  logic [1:0]              arg_count_i,
  input  logic [1:0]              tag_a_i,
  input  logic [1:0]              tag_b_i,
  input  logic [1:0]              tag_c_i,
  input  logic [vsba_pkg::DW-1:0] operand_a_i,
  input  logic [vsba_pkg::DW-1:0] operand_b_i,
  input  logic [vsba_pkg::DW-1:0] operand_c_i,
  output logic                    valid_o,
  output vsba_pkg::pipe_t         data_o
);
  import vsba_pkg::*;

  logic [VW-1:0] a, b, c, clip_lo, lower_v, upper_v;
  logic [7:0]    a8, a8_low;
  logic          hz, is_up, is_lo, num_a, num_b, num_c;
  logic [1:0]    arity;
  kind_e         kind;
  pipe_t         d;
  logic          valid_q;
  pipe_t         data_q;

  assign a    = operand_a_i[VW-1:0];
  assign b    = operand_b_i[VW-1:0];
  assign c    = operand_c_i[VW-1:0];
  assign kind = kind_e'(kind_i);

  // A value counts as a character code only when every bit above the low byte is zero.
  assign hz      = (a[VW-1:8] == '0);
  assign a8      = a[7:0];
  assign is_up   = hz && (a8 >= 8'h41) && (a8 <= 8'h5a);
  assign is_lo   = hz && (a8 >= 8'h61) && (a8 <= 8'h7a);
  assign a8_low  = is_up ? (a8 + CASE_DIST) : a8;
  assign lower_v = is_up ? (a + VW'(CASE_DIST)) : a;
  assign upper_v = is_lo ? (a - VW'(CASE_DIST)) : a;
  assign clip_lo = ($signed(a) < $signed(b)) ? b : a;
  assign num_a   = (tag_a_i == TAG_INT) || (tag_a_i == TAG_FLOAT);
  assign num_b   = (tag_b_i == TAG_INT) || (tag_b_i == TAG_FLOAT);
  assign num_c   = (tag_c_i == TAG_INT) || (tag_c_i == TAG_FLOAT);

  always_comb begin
    unique case (kind)
      K_CLIP:                       arity = 2'd3;
      K_MIN, K_MAX, K_IDIV, K_IMOD: arity = 2'd2;
      default:                      arity = 2'd1;
    endcase
  end

  always_comb begin
    d           = '0;
    d.rem       = '0;
    d.quo       = a[VW-1] ? (VW'(0) - a) : a;
    d.ub        = b[VW-1] ? (VW'(0) - b) : b;
    d.bval      = b;
    d.neg_a     = a[VW-1];
    d.neg_b     = b[VW-1];
    d.res_tag   = RES_INT;
    d.status    = ST_OK;
    if (kind_i == 4'hf || arg_count_i != arity) begin
      d.status = ST_TYPE;
    end else begin
      unique case (kind)
        K_ABS: begin
          if (!num_a) d.status = ST_TYPE;
          else if (tag_a_i == TAG_FLOAT) d.status = ST_FLOAT;
          else d.res_value = a[VW-1] ? (VW'(0) - a) : a;
        end
        K_MIN, K_MAX: begin
          if (!num_a || !num_b || tag_a_i != tag_b_i) d.status = ST_TYPE;
          else if (tag_a_i == TAG_FLOAT) d.status = ST_FLOAT;
          else if (kind == K_MIN) d.res_value = ($signed(b) < $signed(a)) ? b : a;
          else d.res_value = ($signed(a) < $signed(b)) ? b : a;
        end
        K_CLIP: begin
          if (!num_a || !num_b || !num_c || tag_a_i != tag_b_i || tag_a_i != tag_c_i)
            d.status = ST_TYPE;
          else if (tag_a_i == TAG_FLOAT) d.status = ST_FLOAT;
          else d.res_value = ($signed(c) < $signed(clip_lo)) ? c : clip_lo;
        end
        K_IDIV, K_IMOD: begin
          if (tag_a_i != TAG_INT || tag_b_i != TAG_INT) d.status = ST_TYPE;
          else if (b != '0) begin
            d.is_div = 1'b1;
            d.is_mod = (kind == K_IMOD);
          end
        end
        K_ISINT: begin
          d.res_tag   = RES_BOOL;
          d.res_value = VW'(tag_a_i == TAG_INT);
        end
        K_ORD: begin
          if (tag_a_i != TAG_CHAR) d.status = ST_TYPE;
          else d.res_value = a;
        end
        K_CHR: begin
          if (tag_a_i != TAG_INT) d.status = ST_TYPE;
          else if (!hz || a8 > CHAR_MAX_CODE) d.status = ST_VALUE;
          else begin
            d.res_value = a;
            d.res_tag   = RES_CHAR;
          end
        end
        default: begin
          if (tag_a_i != TAG_CHAR) d.status = ST_TYPE;
          else begin
            unique case (kind)
              K_LETTER: begin
                d.res_tag   = RES_BOOL;
                d.res_value = VW'(is_up || is_lo);
              end
              K_DIGIT: begin
                d.res_tag   = RES_BOOL;
                d.res_value = VW'(hz && a8 >= 8'h30 && a8 <= 8'h39);
              end
              K_SPACE: begin
                d.res_tag   = RES_BOOL;
                d.res_value = VW'(hz && (a8 == 8'h20 || (a8 >= 8'h09 && a8 <= 8'h0d)));
              end
              K_VOWEL: begin
                d.res_tag   = RES_BOOL;
                d.res_value = VW'(hz && (a8_low == 8'h61 || a8_low == 8'h65 ||
                                         a8_low == 8'h69 || a8_low == 8'h6f ||
                                         a8_low == 8'h75));
              end
              K_LOWER: begin
                d.res_tag   = RES_CHAR;
                d.res_value = lower_v;
              end
              default: begin
                d.res_tag   = RES_CHAR;
                d.res_value = upper_v;
              end
            endcase
          end
        end
      endcase
    end
    if (d.status != ST_OK) begin
      d.res_value = '0;
      d.res_tag   = RES_INT;
      d.is_div    = 1'b0;
      d.is_mod    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/core/vsba_div_step.sv]
// One registered step of the restoring divider: one quotient bit per stage.
module vsba_div_step (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  vsba_pkg::pipe_t data_i,
  output logic            valid_o,
  output vsba_pkg::pipe_t data_o
);
  import vsba_pkg::*;

  logic [VW:0] trial;
  logic [VW:0] diff;
  logic        take;
  pipe_t       d;
  logic        valid_q;
  pipe_t       data_q;

  assign trial = {data_i.rem, data_i.quo[VW-1]};
  assign diff  = trial - {1'b0, data_i.ub};
  assign take  = !diff[VW];

  always_comb begin
    d     = data_i;
    d.rem = take ? diff[VW-1:0] : trial[VW-1:0];
    d.quo = {data_i.quo[VW-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/core/vsba_out.sv]
// Last stage: sign fix-up of quotient and remainder, result select and output skid buffer.
module vsba_out (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  vsba_pkg::pipe_t       data_i,
  output logic                  en_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output vsba_pkg::out_item_t   item_o
);
  import vsba_pkg::*;

  logic [VW-1:0] q, r, rf, v;
  out_item_t     fin;
  logic          out_v_q, skid_v_q;
  out_item_t     out_q, skid_q;

  assign q  = (data_i.neg_a ^ data_i.neg_b) ? (VW'(0) - data_i.quo) : data_i.quo;
  assign r  = data_i.neg_a ? (VW'(0) - data_i.rem) : data_i.rem;
  // Floor modulo: a nonzero remainder takes the sign of the divisor.
  assign rf = (r != '0 && r[VW-1] != data_i.neg_b) ? (r + data_i.bval) : r;
  assign v  = data_i.is_div ? (data_i.is_mod ? rf : q) : data_i.res_value;

  always_comb begin
    fin.value  = DW'(signed'(v));
    fin.tag    = data_i.res_tag;
    fin.status = data_i.status;
  end

  assign en_o = !skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (ready_i) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (out_v_q && !ready_i) begin
      skid_v_q <= valid_i;
    end else begin
      out_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (ready_i) out_q <= skid_q;
    end else if (out_v_q && !ready_i) begin
      skid_q <= fin;
    end else begin
      out_q <= fin;
    end
  end

  assign valid_o = out_v_q;
  assign item_o  = out_q;

endmodule

[rtl/core/vm_scalar_builtin_alu_top.sv]
// Top level of the scalar builtin ALU: decode stage, divider steps and output stage.
//
// Usage: items enter on the s_axis channel and each one gives exactly one result
// item on the m_axis channel, in order. The input carries the opcode in tuser and
// the argument count, three operand tags and three 64-bit operands in tdata. The
// result carries the value and status in tdata and the result type in tuser.
// Each item passes through one decode stage, one restoring divider step per value
// bit, and the output register on its way to m_axis_tvalid. Every opcode travels
// the same path, so while the pipeline does not stall one item is accepted per
// cycle and results leave at one per cycle.
// The whole pipeline advances together; a two-entry output buffer lets it keep
// moving after the receiver drops m_axis_tready, until an item has to wait in the
// second entry; s_axis_tready then falls until that entry drains. Nothing is lost
// or repeated. Reset clears all valid bits; the block is ready for items as soon
// as reset is released.
module vm_scalar_builtin_alu_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // arg_count[1:0], tag_a[3:2], tag_b[5:4], tag_c[7:6],
  // operand_a[71:8], operand_b[135:72], operand_c[199:136]
  input  logic [199:0] s_axis_tdata,
  // kind[3:0]
  input  logic [3:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_value[63:0], status[65:64], zero fill[71:66]
  output logic [71:0]  m_axis_tdata,
  // result_tag[1:0]
  output logic [1:0]   m_axis_tuser
);
  import vsba_pkg::*;

  logic      en;
  logic      v   [VW+1];
  pipe_t     p   [VW+1];
  out_item_t item;

  assign s_axis_tready = en;

  vsba_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (s_axis_tvalid),
    .kind_i      (s_axis_tuser),
    .arg_count_i (s_axis_tdata[1:0]),
    .tag_a_i     (s_axis_tdata[3:2]),
    .tag_b_i     (s_axis_tdata[5:4]),
    .tag_c_i     (s_axis_tdata[7:6]),
    .operand_a_i (s_axis_tdata[71:8]),
    .operand_b_i (s_axis_tdata[135:72]),
    .operand_c_i (s_axis_tdata[199:136]),
    .valid_o     (v[0]),
    .data_o      (p[0])
  );

  for (genvar i = 0; i < VW; i++) begin : g_div
    vsba_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v[i]),
      .data_i  (p[i]),
      .valid_o (v[i+1]),
      .data_o  (p[i+1])
    );
  end

  vsba_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v[VW] && en),
    .data_i  (p[VW]),
    .en_o    (en),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .item_o  (item)
  );

  assign m_axis_tdata = {6'b0, item.status, item.value};
  assign m_axis_tuser = item.tag;

`include "vm_scalar_builtin_alu_top_assert.svh"

  `VSBA_ASSERT(a_err_zero, m_axis_tvalid && item.status != ST_OK,
               item.value == '0 && item.tag == RES_INT,
               "error result carries a nonzero value or tag")
  `VSBA_ASSERT(a_bool_bit, m_axis_tvalid && item.tag == RES_BOOL,
               item.value[DW-1:1] == '0 && item.status == ST_OK,
               "boolean result is not 0 or 1")
  `VSBA_ASSERT(a_skid_behind_out, !s_axis_tready, m_axis_tvalid,
               "output buffer holds an item while the output register is empty")
  `VSBA_ASSERT_NEXT(a_stall_frees, !s_axis_tready && m_axis_tready, s_axis_tready,
                    "input stays blocked after the receiver took an item")

endmodule
